// ----- rtl/core/touch_key_hysteresis_events_macros.svh -----
// Assertion macros shared by the checker of touch_key_hysteresis_events.
`ifndef TOUCH_KEY_HYSTERESIS_EVENTS_MACROS_SVH
`define TOUCH_KEY_HYSTERESIS_EVENTS_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define TKHE_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tkhe check failed");

// Next-cycle implication, off while reset is high.
`define TKHE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tkhe check failed");

// Next-cycle implication that also covers the reset cycles.
`define TKHE_ASSERT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("tkhe check failed");

`endif

// ----- rtl/core/tkhe_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package tkhe_pkg;

   localparam int CHANNELS    = 3;
   localparam int READING_W   = 16;
   localparam int TIME_W      = 32;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [READING_W-1:0] PRESS_RESET   = 16'd150;
   localparam logic [READING_W-1:0] RELEASE_RESET = 16'd50;
   localparam logic [READING_W-1:0] MOVE_RESET    = 16'd100;

   localparam logic [CSR_INDEX_W-1:0] REG_PRESS   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_RELEASE = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_MOVE    = 2'd2;

   typedef enum logic [1:0] {
      EV_NONE = 2'd0,
      EV_DOWN = 2'd1,
      EV_UP   = 2'd2,
      EV_MOVE = 2'd3
   } event_type;

   typedef struct packed {
      logic [READING_W-1:0] reading_a;
      logic [READING_W-1:0] reading_b;
      logic [READING_W-1:0] reading_c;
      logic [TIME_W-1:0]    now_ms;
   } req_type;

   typedef struct packed {
      logic [1:0]          event_a;
      logic [1:0]          event_b;
      logic [1:0]          event_c;
      logic [CHANNELS-1:0] touched_mask;
   } rsp_type;

   typedef struct packed {
      logic [READING_W-1:0] press_threshold;
      logic [READING_W-1:0] release_threshold;
      logic [READING_W-1:0] move_interval_ms;
   } cfg_type;

endpackage

`default_nettype wire

// ----- rtl/core/touch_key_hysteresis_events.sv -----
// Channel | Direction | Handshake          | Payload
// req     | in        | req_valid/req_stall | req_type: three readings, now_ms
// rsp     | out       | rsp_valid/rsp_stall | rsp_type: three events, touched_mask
// csr     | in        | csr_valid/csr_ready | csr_index, csr_wdata (low 16 bits)
//
// One request per cycle while req_stall is low; a taken request passes the request register
// and then the response register. The throughput is set by the single compare/subtract pass
// per channel between the request register and the response register.
// Reset is synchronous: flags, move times and threshold registers return to their defaults.
// A stalled response holds; a second request waits in the request register.
`timescale 1ns / 1ps
`default_nettype none

module touch_key_hysteresis_events
   import tkhe_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire req_type                req_payload,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output rsp_type                     rsp_payload,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic    s1_valid_ff;
   logic    s1_valid_in;
   req_type s1_data_ff;
   logic    rsp_valid_ff;
   logic    rsp_valid_in;
   rsp_type rsp_data_ff;
   rsp_type rsp_data_in;
   logic    out_free;
   logic    advance;
   logic    req_take;
   cfg_type cfg;

   logic [READING_W-1:0] reading [CHANNELS];
   event_type            chan_event [CHANNELS];
   logic [CHANNELS-1:0]  touched_next;

   assign csr_ready = 1'b1;

   tkhe_regs u_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   assign s1_valid_in  = req_take || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   assign reading[0] = s1_data_ff.reading_a;
   assign reading[1] = s1_data_ff.reading_b;
   assign reading[2] = s1_data_ff.reading_c;

   for (genvar i = 0; i < CHANNELS; i++) begin : g_chan
      tkhe_chan u_chan (
         .clock        (clock),
         .reset        (reset),
         .advance      (advance),
         .reading      (reading[i]),
         .now_ms       (s1_data_ff.now_ms),
         .cfg          (cfg),
         .chan_event   (chan_event[i]),
         .touched_next (touched_next[i])
      );
   end

   always_comb begin
      rsp_data_in.event_a      = chan_event[0];
      rsp_data_in.event_b      = chan_event[1];
      rsp_data_in.event_c      = chan_event[2];
      rsp_data_in.touched_mask = touched_next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_data_ff <= req_payload;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

endmodule

`default_nettype wire

// ----- rtl/core/tkhe_regs.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tkhe_regs
   import tkhe_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_valid,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   output cfg_type                     cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_PRESS:   cfg_in.press_threshold   = csr_wdata;
            REG_RELEASE: cfg_in.release_threshold = csr_wdata;
            REG_MOVE:    cfg_in.move_interval_ms  = csr_wdata;
            default:     cfg_in = cfg_ff;   // drop writes to unused indexes
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.press_threshold   <= PRESS_RESET;
         cfg_ff.release_threshold <= RELEASE_RESET;
         cfg_ff.move_interval_ms  <= MOVE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ----- rtl/core/tkhe_chan.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tkhe_chan
   import tkhe_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 advance,
   input  wire logic [READING_W-1:0] reading,
   input  wire logic [TIME_W-1:0]    now_ms,
   input  wire cfg_type              cfg,
   output event_type                 chan_event,
   output logic                      touched_next
);

   logic              touched_ff;
   logic              touched_in;
   logic [TIME_W-1:0] last_move_ff;
   logic [TIME_W-1:0] last_move_in;
   logic [TIME_W-1:0] elapsed;
   logic              move_due;

   always_comb begin
      touched_in = (reading > cfg.press_threshold) ||
                   (touched_ff && (reading > cfg.release_threshold));
      elapsed    = now_ms - last_move_ff;   // wraps modulo 2^32
      move_due   = touched_ff && touched_in &&
                   (elapsed > {{(TIME_W-READING_W){1'b0}}, cfg.move_interval_ms});

      last_move_in = last_move_ff;
      if (touched_in != touched_ff) begin
         chan_event = touched_in ? EV_DOWN : EV_UP;
      end else if (move_due) begin
         chan_event   = EV_MOVE;
         last_move_in = now_ms;
      end else begin
         chan_event = EV_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         touched_ff   <= 1'b0;
         last_move_ff <= '0;
      end else if (advance) begin
         touched_ff   <= touched_in;
         last_move_ff <= last_move_in;
      end
   end

   assign touched_next = touched_in;

endmodule

`default_nettype wire

// ----- rtl/core/tkhe_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "touch_key_hysteresis_events_macros.svh"

module tkhe_checker
   import tkhe_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_stall,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_payload
);

   logic ev_a_set;
   logic ev_a_up;

   assign ev_a_set = rsp_valid &&
                     (rsp_payload.event_a == EV_DOWN || rsp_payload.event_a == EV_MOVE);
   assign ev_a_up  = rsp_valid && (rsp_payload.event_a == EV_UP);

   // A down or move on channel 0 leaves it touched; an up leaves it released.
   `TKHE_ASSERT_NOW(a_down_move_touched, clock, reset, ev_a_set, rsp_payload.touched_mask[0])
   `TKHE_ASSERT_NOW(a_up_released, clock, reset, ev_a_up, !rsp_payload.touched_mask[0])

   // Requests back up only behind a stalled response.
   `TKHE_ASSERT_NOW(a_stall_only_when_full, clock, reset, req_stall, rsp_valid && rsp_stall)

   // Reset empties the pipeline.
   `TKHE_ASSERT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid && !req_stall)

endmodule

bind touch_key_hysteresis_events tkhe_checker u_tkhe_checker (.*);

`default_nettype wire
